### rtl/core/blake2b_hash_defines.svh
// Assertion macros for the hash core
`ifndef BLAKE2B_HASH_DEFINES_SVH
`define BLAKE2B_HASH_DEFINES_SVH

// property must hold at every clock edge outside reset
`define B2B_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define B2B_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/b2b_pkg.sv
`default_nettype none
package b2b_pkg;
	localparam int ROUNDS = 12;
	localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0000;

	typedef logic [63:0] word_t;

	localparam word_t IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	typedef logic [3:0] perm_row_t [16];
	localparam perm_row_t SIGMA [10] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

	// G-function mixing indices a,b,c,d for each of the eight steps of a round
	typedef logic [3:0] g_idx_t [4];
	localparam g_idx_t GIDX [8] = '{
		'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
		'{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
		'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
		'{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}
	};

	localparam logic [1:0] REG_DIGEST_LEN = 2'd0;

	typedef struct packed {
		logic start;
		logic final_blk;
	} cmp_ctl_t;

	function automatic logic [6:0] clamp_len(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (v == 7'd0) r = 7'd1;
		else if (v > 7'd64) r = 7'd64;
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/core/b2b_compress.sv
`default_nettype none
`include "blake2b_hash_defines.svh"
module b2b_compress
	import b2b_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmp_ctl_t    ctl,
	input  wire word_t       h_in [8],
	input  wire word_t       m_in [16],
	input  wire logic [63:0] t_lo,
	input  wire logic [63:0] t_hi,
	output logic             busy,
	output logic             done,
	output word_t            h_out [8]
);
	// one G half-step per cycle while busy; each of the 12 rounds runs 8 G in 2 halves
	word_t       v_q [16];
	logic [3:0]  rnd_q;
	logic [3:0]  sig_q;
	logic [2:0]  g_q;
	logic        half_q;
	logic        busy_q;
	logic        done_q;

	logic [3:0]  ia, ib, ic, id;
	word_t       va, vb, vc, vd, mw, na, nb, nc, nd;

	always_comb begin
		ia = GIDX[g_q][0];
		ib = GIDX[g_q][1];
		ic = GIDX[g_q][2];
		id = GIDX[g_q][3];
		va = v_q[ia];
		vb = v_q[ib];
		vc = v_q[ic];
		vd = v_q[id];
		mw = m_in[SIGMA[sig_q][{g_q, half_q}]];
		na = va + vb + mw;
		if (!half_q) begin
			nd = {vd ^ na} >> 32 | {vd ^ na} << 32;
			nc = vc + nd;
			nb = (vb ^ nc) >> 24 | (vb ^ nc) << 40;
		end else begin
			nd = (vd ^ na) >> 16 | (vd ^ na) << 48;
			nc = vc + nd;
			nb = (vb ^ nc) >> 63 | (vb ^ nc) << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
			sig_q  <= '0;
			g_q    <= '0;
			half_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				sig_q  <= '0;
				g_q    <= '0;
				half_q <= 1'b0;
			end else if (busy_q) begin
				half_q <= ~half_q;
				if (half_q) begin
					g_q <= g_q + 3'd1;
					if (g_q == 3'd7) begin
						sig_q <= (sig_q == 4'd9) ? 4'd0 : sig_q + 4'd1;
						rnd_q <= rnd_q + 4'd1;
						if (rnd_q == 4'(ROUNDS - 1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i]     <= h_in[i];
				v_q[i + 8] <= IV[i];
			end
			v_q[12] <= IV[4] ^ t_lo;
			v_q[13] <= IV[5] ^ t_hi;
			v_q[14] <= ctl.final_blk ? ~IV[6] : IV[6];
		end else if (busy_q) begin
			v_q[ia] <= na;
			v_q[ib] <= nb;
			v_q[ic] <= nc;
			v_q[id] <= nd;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++)
			h_out[i] = h_in[i] ^ v_q[i] ^ v_q[i + 8];
	end

	assign busy = busy_q;
	assign done = done_q;

	`B2B_ASSERT(a_rnd_range, !busy_q || rnd_q < 4'(ROUNDS), "round count overrun")
	`B2B_ASSERT(a_done_idle, !(done_q && busy_q), "done while busy")
	`B2B_ASSERT_NEXT(a_start, ctl.start && !busy_q, busy_q, "start not taken")
endmodule
`default_nettype wire

### rtl/core/blake2b_hash.sv
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid/s_tready         s_tdata{msg_word,byte_count}, s_tlast
// m_axis    out  m_tvalid/m_tready         m_tdata{digest_word}, m_tlast
// apb       in   psel/penable/pwrite        digest_len at 0x0
// A beat is accepted in idle, then its bytes are packed one byte per cycle (held
// while a full buffer is compressed), then a wrap-up step follows. A block
// compression runs start, the G half-steps in the shared unit, then done.
// s_tready is high only in idle.
// Digest beats stall on m_tready. Reset restores IV state and digest_len 64.
`default_nettype none
`include "blake2b_hash_defines.svh"
module blake2b_hash
	import b2b_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // msg_word[63:0], byte_count[67:64], zero pad
	input  wire logic        s_tlast,   // last_word
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // digest_word[63:0]
	output logic             m_tlast,   // digest_last
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_BYTE = 3'd1, ST_CMP = 3'd2,
		ST_FIN = 3'd3, ST_OUT = 3'd4;

	logic [2:0]  st_q;
	logic [6:0]  dlen_q, used_q;
	logic        idle_q;
	word_t       h_q [8];
	word_t       buf_q [16];
	logic [7:0]  fill_q;
	logic [63:0] tlo_q, thi_q;
	logic [63:0] word_q;
	logic [3:0]  cnt_q, bi_q;
	logic        last_q;
	logic [2:0]  oi_q;
	cmp_ctl_t    ctl;
	logic        cbusy, cdone;
	word_t       h_new [8];
	logic [6:0]  have;
	logic [63:0] mask;
	logic [3:0]  cnt_in;

	b2b_compress u_cmp (
		.clk, .arst_n, .ctl, .h_in(h_q), .m_in(buf_q), .t_lo(tlo_q), .t_hi(thi_q),
		.busy(cbusy), .done(cdone), .h_out(h_new)
	);

	assign pready = 1'b1;
	assign prdata = {25'd0, dlen_q};
	assign s_tready = (st_q == ST_IDLE);
	assign cnt_in = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];

	always_comb begin
		ctl.start = 1'b0;
		ctl.final_blk = 1'b0;
		if (st_q == ST_CMP && !cbusy && !cdone) ctl.start = 1'b1;
		if (st_q == ST_FIN && !cbusy && !cdone) begin
			ctl.start = 1'b1;
			ctl.final_blk = 1'b1;
		end
		have = used_q - {1'b0, oi_q, 3'd0};
		mask = (have >= 7'd8) ? '1 : ((64'd1 << {have[2:0], 3'd0}) - 64'd1);
	end

	assign m_tvalid = (st_q == ST_OUT);
	assign m_tdata = h_q[oi_q] & mask;
	assign m_tlast = (have <= 7'd8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			dlen_q <= 7'd64;
			used_q <= 7'd64;
			idle_q <= 1'b1;
			fill_q <= '0;
			tlo_q  <= '0;
			thi_q  <= '0;
			oi_q   <= '0;
			bi_q   <= '0;
			cnt_q  <= '0;
			last_q <= 1'b0;
			word_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= (i == 0) ? IV[0] ^ PARAM_WORD ^ 64'd64 : IV[i];
			for (int i = 0; i < 16; i++) buf_q[i] <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_DIGEST_LEN)
				dlen_q <= pwdata[6:0];
			unique case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						word_q <= s_tdata[63:0];
						cnt_q  <= cnt_in;
						last_q <= s_tlast;
						bi_q   <= '0;
						st_q   <= ST_BYTE;
						if (idle_q) begin
							idle_q <= 1'b0;
							used_q <= clamp_len(dlen_q);
							for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
							h_q[0] <= IV[0] ^ PARAM_WORD ^ {57'd0, clamp_len(dlen_q)};
							for (int i = 0; i < 16; i++) buf_q[i] <= '0;
							fill_q <= '0;
							tlo_q <= '0;
							thi_q <= '0;
						end
					end
				end
				ST_BYTE: begin
					if (bi_q == cnt_q) begin
						if (last_q) st_q <= ST_FIN;
						else st_q <= ST_IDLE;
					end else if (fill_q[7]) begin
						st_q <= ST_CMP;
					end else begin
						buf_q[fill_q[6:3]] <= buf_q[fill_q[6:3]] |
							({56'd0, word_q[7:0]} << {fill_q[2:0], 3'd0});
						word_q <= word_q >> 8;
						bi_q   <= bi_q + 4'd1;
						fill_q <= fill_q + 8'd1;
						tlo_q  <= tlo_q + 64'd1;
						if (tlo_q == '1) thi_q <= thi_q + 64'd1;
					end
				end
				ST_CMP, ST_FIN: begin
					if (cdone) begin
						for (int i = 0; i < 8; i++) h_q[i] <= h_new[i];
						if (st_q == ST_CMP) begin
							for (int i = 0; i < 16; i++) buf_q[i] <= '0;
							fill_q <= '0;
							st_q <= ST_BYTE;
						end else begin
							oi_q <= '0;
							st_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						oi_q <= oi_q + 3'd1;
						if (m_tlast) begin
							st_q   <= ST_IDLE;
							idle_q <= 1'b1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`B2B_ASSERT(a_fill, fill_q <= 8'd128, "buffer overfill")
	`B2B_ASSERT(a_out_len, !m_tvalid || {oi_q, 3'd0} < used_q, "digest index past length")
	`B2B_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready,
		"not idle after digest")
	`B2B_ASSERT(a_cmp_state, !cbusy || st_q == ST_CMP || st_q == ST_FIN,
		"compressor busy outside compress")
endmodule
`default_nettype wire

### test/tb_blake2b_hash.sv
`default_nettype none
module tb_blake2b_hash;
	import b2b_pkg::*;

	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE = 300;

	localparam logic [63:0] H_IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};
	localparam int PERM [10][16] = '{
		'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
		'{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
		'{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
		'{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
		'{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
		'{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
		'{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
		'{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
		'{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
		'{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
	};
	localparam int MIX [8][4] = '{
		'{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
		'{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
	};

	typedef struct {
		word_t word;
		logic  last;
	} digest_beat_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [71:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [63:0] m_tdata;
	logic m_tlast;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	blake2b_hash u_top (.*);

	// hash state of the predictor
	logic [6:0] len_reg;
	word_t chain [8];
	logic [7:0] blk_bytes [128];
	int blk_fill;
	logic [127:0] byte_total;
	bit between_msgs;
	int msg_len;

	digest_beat_t digest_q [$];
	int errors;
	int idle_cycles;
	bit no_gaps;
	int rx_hold;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic void compress_block(bit fin);
		word_t v [16];
		word_t m [16];
		int a, b, c, d;
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 8; j++)
				m[i][8*j +: 8] = blk_bytes[8*i + j];
		end
		for (int i = 0; i < 8; i++) begin
			v[i] = chain[i];
			v[i+8] = H_IV[i];
		end
		v[12] ^= byte_total[63:0];
		v[13] ^= byte_total[127:64];
		if (fin)
			v[14] = ~v[14];
		for (int r = 0; r < ROUNDS; r++) begin
			for (int k = 0; k < 8; k++) begin
				a = MIX[k][0]; b = MIX[k][1]; c = MIX[k][2]; d = MIX[k][3];
				v[a] = v[a] + v[b] + m[PERM[r % 10][2*k]];
				v[d] = rotr(v[d] ^ v[a], 32);
				v[c] = v[c] + v[d];
				v[b] = rotr(v[b] ^ v[c], 24);
				v[a] = v[a] + v[b] + m[PERM[r % 10][2*k+1]];
				v[d] = rotr(v[d] ^ v[a], 16);
				v[c] = v[c] + v[d];
				v[b] = rotr(v[b] ^ v[c], 63);
			end
		end
		for (int i = 0; i < 8; i++)
			chain[i] ^= v[i] ^ v[i+8];
	endfunction

	function automatic void begin_message();
		msg_len = (len_reg == 0) ? 1 : (len_reg > 64) ? 64 : int'(len_reg);
		for (int i = 0; i < 8; i++)
			chain[i] = H_IV[i];
		chain[0] ^= 64'h0101_0000 | 64'(msg_len);
		foreach (blk_bytes[i])
			blk_bytes[i] = 8'h00;
		blk_fill = 0;
		byte_total = '0;
	endfunction

	function automatic void absorb_word(word_t w, logic [3:0] cnt_in, logic fin);
		int cnt;
		int nw;
		int have;
		word_t dw;
		digest_beat_t e;
		cnt = (cnt_in > 8) ? 8 : int'(cnt_in);
		if (between_msgs) begin
			begin_message();
			between_msgs = 1'b0;
		end
		for (int i = 0; i < cnt; i++) begin
			if (blk_fill >= 128) begin
				compress_block(1'b0);
				foreach (blk_bytes[j])
					blk_bytes[j] = 8'h00;
				blk_fill = 0;
			end
			blk_bytes[blk_fill] = w[8*i +: 8];
			blk_fill++;
			byte_total++;
		end
		if (fin) begin
			compress_block(1'b1);
			nw = (msg_len + 7) / 8;
			for (int i = 0; i < nw; i++) begin
				dw = chain[i];
				have = msg_len - 8*i;
				if (have < 8)
					dw &= (64'd1 << (8*have)) - 64'd1;
				e.word = dw;
				e.last = (i + 1 == nw);
				digest_q.push_back(e);
			end
			between_msgs = 1'b1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send_word(word_t w, logic [3:0] cnt, logic fin);
		int g;
		g = pick_gap();
		repeat (g) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {4'h0, cnt, w};
		s_tlast = fin;
		do
			@(posedge clk);
		while (!s_tready);
		absorb_word(w, cnt, fin);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_message(int nbytes);
		int left;
		left = nbytes;
		while (left > 8) begin
			send_word(rand_word(), 4'd8, 1'b0);
			left -= 8;
		end
		send_word(rand_word(), 4'(left), 1'b1);
	endtask

	task automatic apb_write(logic [1:0] addr, logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == REG_DIGEST_LEN)
			len_reg = data[6:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain();
		wait (digest_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_len(logic [6:0] n);
		drain();
		apb_write(REG_DIGEST_LEN, {25'd0, n});
	endtask

	task automatic test_directed();
		send_word(rand_word(), 4'd0, 1'b1);
		send_word(64'h0000_0000_0063_6261, 4'd3, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
		send_message(128);
		send_word(64'h0000_0000_0000_0000, 4'd8, 1'b1);
		send_word(rand_word(), 4'd5, 1'b0);
		send_word(rand_word(), 4'd12, 1'b0);
		send_word(rand_word(), 4'd15, 1'b1);
	endtask

	task automatic test_digest_lengths();
		logic [6:0] lens [7] = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd64, 7'd33, 7'd9};
		foreach (lens[i]) begin
			set_len(lens[i]);
			send_message($urandom_range(0, 20));
			send_message($urandom_range(120, 140));
		end
	endtask

	task automatic test_random_messages();
		int r;
		int sent;
		int left;
		int c;
		sent = 0;
		while (sent < 200) begin
			if (sent % 60 == 0)
				set_len(7'($urandom_range(0, 127)));
			no_gaps = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			if (r < 10)
				left = $urandom_range(256, 400);
			else
				left = $urandom_range(0, 150);
			while (left > 8) begin
				c = 8;
				// occasional short or oversized word mid-message
				if ($urandom_range(0, 9) == 0)
					c = $urandom_range(0, 15);
				send_word(rand_word(), 4'(c), 1'b0);
				left -= (c > 8) ? 8 : c;
				sent++;
			end
			c = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : left;
			send_word(rand_word(), 4'(c), 1'b1);
			sent++;
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_backpressure();
		set_len(7'd64);
		rx_hold = 800;
		no_gaps = 1'b1;
		repeat (4)
			send_message($urandom_range(0, 24));
		no_gaps = 1'b0;
		wait (digest_q.size() == 0);
		@(negedge clk);
		send_message(40);
		wait (digest_q.size() == 0);
		@(negedge clk);
		send_message(8);
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (no_gaps) begin
			m_tready <= 1'b1;
		end else begin
			case ($urandom_range(0, 19))
				0: rx_hold <= $urandom_range(10, 60);
				1, 2, 3, 4, 5: m_tready <= 1'b0;
				default: m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		digest_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 64'd0);
			end else begin
				e = digest_q.pop_front();
				if (m_tdata !== e.word)
					report_mismatch("digest_word", m_tdata, e.word);
				if (m_tlast !== e.last)
					report_mismatch("digest_last", 64'(m_tlast), 64'(e.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		rx_hold = 0;
		len_reg = 7'd64;
		between_msgs = 1'b1;
		begin_message();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_digest_lengths();
		test_random_messages();
		test_backpressure();
		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+rtl/core
rtl/core/b2b_pkg.sv
rtl/core/b2b_compress.sv
rtl/core/blake2b_hash.sv
test/tb_blake2b_hash.sv
